// ----- rtl/core/kmp_substring_search_core_macros.svh -----
// Assertion helpers for the substring search core.
// Both expect clk_i and rst_ni in scope.
`ifndef KMP_SUBSTRING_SEARCH_CORE_MACROS_SVH
`define KMP_SUBSTRING_SEARCH_CORE_MACROS_SVH

// Property checked at every clock edge outside reset.
`define KSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define KSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/kss_pkg.sv -----
// ----------------------------------------------------------------------------
// kss_pkg
// Types and constants shared by the substring search core.
// ----------------------------------------------------------------------------
`default_nettype none

package kss_pkg;

  localparam int PATTERN_DEPTH = 32;
  localparam int POS_W         = 16;

  // length / index widths
  localparam int KW  = $clog2(PATTERN_DEPTH + 1);
  localparam int FAW = KW;
  localparam int SAW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  localparam logic CMD_PATTERN = 1'b0;
  localparam logic CMD_TEXT    = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] byte_value;
    logic       last;
  } kss_in_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] match_position;
    logic             pattern_overflow;
    logic             position_saturated;
  } kss_out_t;

  // classified request handed from front to engine
  typedef struct packed {
    logic       is_text;
    logic [7:0] byte_value;
    logic       last;
  } kss_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_DONE
  } kss_state_e;

endpackage

`default_nettype wire

// ----- rtl/core/kmp_substring_search_core.sv -----
// Flow: a text byte with last set passes the front queue, walks the failure table in
// ST_STEP (skipped when no search is due) and is issued from ST_DONE to the output register.
// A pattern byte enters ST_STEP only when it is neither a first nor a dropped byte. The engine
// takes a new byte only in ST_IDLE; the front queue holds up to two bytes while it is busy.
// Reset: control state clears at once; pattern and failure RAMs are undefined until
// loaded and get no clearing pass. start_offset resets to 0.
// ----------------------------------------------------------------------------
// kmp_substring_search_core
// Knuth-Morris-Pratt substring search: front queue, table-walk engine.
// ----------------------------------------------------------------------------
`default_nettype none

module kmp_substring_search_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire kss_pkg::kss_in_t           in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output kss_pkg::kss_out_t               out_data_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [kss_pkg::POS_W-1:0]  cfg_wdata_i
);
  import kss_pkg::*;

  logic [POS_W-1:0] start_offset_q;
  logic             item_valid;
  logic             item_ready;
  kss_item_t        item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_offset_q <= '0;
    end else if (cfg_we_i) begin
      start_offset_q <= cfg_wdata_i;
    end
  end

  kss_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  kss_engine u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_offset_i (start_offset_q),
    .item_valid_i   (item_valid),
    .item_ready_o   (item_ready),
    .item_i         (item),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_data_o     (out_data_o)
  );

endmodule

`default_nettype wire

// ----- rtl/core/kss_ram.sv -----
// ----------------------------------------------------------------------------
// kss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                             wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/core/kss_front.sv -----
// ----------------------------------------------------------------------------
// kss_front
// Accepts input requests, classifies them and buffers them in a two-entry
// queue ahead of the search engine.
// ----------------------------------------------------------------------------
`default_nettype none

module kss_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire kss_pkg::kss_in_t  in_data_i,
  output logic                   item_valid_o,
  input  wire logic              item_ready_i,
  output kss_pkg::kss_item_t     item_o
);
  import kss_pkg::*;

  kss_item_t   slot_q [2];
  logic        wptr_q, wptr_d;
  logic        rptr_q, rptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push, pop;
  kss_item_t   cls;

  always_comb begin
    cls.is_text    = (in_data_i.command == CMD_TEXT);
    cls.byte_value = in_data_i.byte_value;
    cls.last       = in_data_i.last;
  end

  assign in_ready_o   = (cnt_q != 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = slot_q[rptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_valid_o && item_ready_i;

  always_comb begin
    wptr_d = wptr_q ^ push;
    rptr_d = rptr_q ^ pop;
    cnt_d  = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= cls;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/kss_engine.sv -----
// ----------------------------------------------------------------------------
// kss_engine
// KMP back end: builds the failure table from pattern bytes, walks it for
// text bytes and issues the end-of-text result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "kmp_substring_search_core_macros.svh"

module kss_engine (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [kss_pkg::POS_W-1:0]  start_offset_i,
  input  wire logic                       item_valid_i,
  output logic                            item_ready_o,
  input  wire kss_pkg::kss_item_t         item_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output kss_pkg::kss_out_t               out_data_o
);
  import kss_pkg::*;

  kss_state_e       state_q, state_d;
  logic [7:0]       byte_q, byte_d;
  logic             last_q, last_d;
  logic             text_q, text_d;
  logic [KW-1:0]    k_q, k_d;
  logic [KW-1:0]    count_q, count_d;
  logic [KW-1:0]    tracker_q, tracker_d;
  logic [KW-1:0]    matched_q, matched_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             hit_q, hit_d;
  logic [POS_W-1:0] hitpos_q, hitpos_d;
  logic             loading_q, loading_d;
  logic             ovf_q, ovf_d;
  logic             out_valid_q, out_valid_d;
  kss_out_t         out_q, out_d;

  // memory ports
  logic             mem_we;
  logic [SAW-1:0]   pat_waddr;
  logic [FAW-1:0]   fail_waddr;
  logic [KW-1:0]    fail_wdata;
  logic [7:0]       pat_rdata;
  logic [KW-1:0]    fail_rdata;

  // shared decisions
  logic             take;
  logic [KW-1:0]    eff_count;
  logic             pat_full, pat_direct, search_go;
  logic             mismatch;
  logic [KW-1:0]    k_new;
  logic [KW:0]      count_p1;
  logic             out_room;
  logic [POS_W-1:0] pos_n, m1;

  kss_ram #(.WIDTH(8), .DEPTH(PATTERN_DEPTH)) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (pat_waddr),
    .wdata_i (byte_d),
    .raddr_i (k_d[SAW-1:0]),
    .rdata_o (pat_rdata)
  );

  kss_ram #(.WIDTH(KW), .DEPTH(PATTERN_DEPTH + 1)) u_fail_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (fail_waddr),
    .wdata_i (fail_wdata),
    .raddr_i (k_d[FAW-1:0]),
    .rdata_o (fail_rdata)
  );

  assign item_ready_o = (state_q == ST_IDLE);
  assign take         = item_valid_i && item_ready_o;
  assign eff_count    = loading_q ? count_q : '0;
  assign pat_full     = (eff_count >= KW'(PATTERN_DEPTH));
  assign pat_direct   = pat_full || (eff_count == '0);
  assign search_go    = (count_q != '0) && !hit_q && (pos_q >= start_offset_i);
  assign mismatch     = (k_q != '0) && (pat_rdata != byte_q);
  assign k_new        = k_q + KW'(pat_rdata == byte_q);
  assign count_p1     = {1'b0, count_q} + (KW+1)'(1);
  assign out_room     = !out_valid_q || out_ready_i;
  assign pos_n        = (pos_q != POS_MAX) ? pos_q + POS_W'(1) : pos_q;
  assign m1           = POS_W'(count_q) - POS_W'(1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          if (item_i.is_text) begin
            state_d = search_go ? ST_STEP : ST_DONE;
          end else if (!pat_direct) begin
            state_d = ST_STEP;
          end
        end
      end
      ST_STEP: begin
        if (!mismatch) begin
          state_d = text_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_DONE: begin
        if (!last_q || out_room) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    byte_d      = byte_q;
    last_d      = last_q;
    text_d      = text_q;
    k_d         = k_q;
    count_d     = count_q;
    tracker_d   = tracker_q;
    matched_d   = matched_q;
    pos_d       = pos_q;
    hit_d       = hit_q;
    hitpos_d    = hitpos_q;
    loading_d   = loading_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    mem_we      = 1'b0;
    pat_waddr   = count_q[SAW-1:0];
    fail_waddr  = count_p1[FAW-1:0];
    fail_wdata  = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          byte_d = item_i.byte_value;
          last_d = item_i.last;
          text_d = item_i.is_text;
          if (item_i.is_text) begin
            loading_d = 1'b0;
            k_d       = matched_q;
          end else begin
            loading_d = 1'b1;
            if (!loading_q) begin
              // fresh pattern: drop old pattern and any text progress
              count_d   = '0;
              tracker_d = '0;
              ovf_d     = 1'b0;
              pos_d     = '0;
              matched_d = '0;
              hit_d     = 1'b0;
              hitpos_d  = '0;
            end
            if (pat_full) begin
              ovf_d     = 1'b1;
              loading_d = !item_i.last;
            end else if (eff_count == '0) begin
              mem_we     = 1'b1;
              pat_waddr  = '0;
              fail_waddr = FAW'(1);
              fail_wdata = '0;
              count_d    = KW'(1);
              tracker_d  = '0;
              loading_d  = !item_i.last;
            end else begin
              k_d = tracker_q;
            end
          end
        end
      end
      ST_STEP: begin
        if (mismatch) begin
          k_d = (fail_rdata < k_q) ? fail_rdata : '0;
        end else if (text_q) begin
          if (k_new >= count_q) begin
            hit_d     = 1'b1;
            hitpos_d  = (pos_q >= m1) ? pos_q - m1 : '0;
            matched_d = '0;
          end else begin
            matched_d = k_new;
          end
        end else begin
          tracker_d  = ({1'b0, k_new} >= count_p1) ? '0 : k_new;
          mem_we     = 1'b1;
          fail_wdata = tracker_d;
          count_d    = count_p1[KW-1:0];
          loading_d  = !last_q;
        end
      end
      ST_DONE: begin
        if (!last_q) begin
          pos_d = pos_n;
        end else if (out_room) begin
          out_valid_d = 1'b1;
          if (count_q == '0) begin
            out_d.found          = (start_offset_i <= pos_n);
            out_d.match_position = (start_offset_i <= pos_n) ? start_offset_i : '0;
          end else begin
            out_d.found          = hit_q;
            out_d.match_position = hit_q ? hitpos_q : '0;
          end
          out_d.pattern_overflow   = ovf_q;
          out_d.position_saturated = (pos_n == POS_MAX);
          pos_d     = '0;
          matched_d = '0;
          hit_d     = 1'b0;
          hitpos_d  = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      byte_q      <= '0;
      last_q      <= 1'b0;
      text_q      <= 1'b0;
      k_q         <= '0;
      count_q     <= '0;
      tracker_q   <= '0;
      matched_q   <= '0;
      pos_q       <= '0;
      hit_q       <= 1'b0;
      hitpos_q    <= '0;
      loading_q   <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      byte_q      <= byte_d;
      last_q      <= last_d;
      text_q      <= text_d;
      k_q         <= k_d;
      count_q     <= count_d;
      tracker_q   <= tracker_d;
      matched_q   <= matched_d;
      pos_q       <= pos_d;
      hit_q       <= hit_d;
      hitpos_q    <= hitpos_d;
      loading_q   <= loading_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `KSS_ASSERT(a_count_range, count_q <= KW'(PATTERN_DEPTH), "pattern count past store depth")
  `KSS_ASSERT(a_matched_lt_count, (matched_q == '0) || (matched_q < count_q), "partial match too long")
  `KSS_ASSERT(a_step_index, (state_q != ST_STEP) || (k_q < count_q), "table walk beyond pattern")
  `KSS_ASSERT(a_hit_pos, !hit_q || (hitpos_q <= pos_q), "match start after text position")
  `KSS_ASSERT_NEXT(a_done_clears, (state_q == ST_DONE) && last_q && out_room, !hit_q && (pos_q == '0), "text state not cleared after result")

endmodule

`default_nettype wire
